// ----- hdl/krt_pkg.sv -----
// ----------------------------------------------------------------------------
// krt_pkg
// Types and codes shared by the keyed record table modules.
// ----------------------------------------------------------------------------
`default_nettype none
package krt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_LIST   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LIST
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] key;
    logic        [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] rec_key;
    logic        [31:0] rec_value;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic occ;
    logic add_here;
    logic upd;
    logic del;
    logic rotate;
    logic tail;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/krt_cell.sv -----
// ----------------------------------------------------------------------------
// krt_cell
// One record slot of the table: key compare, first-match chain and move logic.
// ----------------------------------------------------------------------------
`default_nettype none
module krt_cell
  import krt_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic signed [31:0] new_key,
  input  wire logic        [31:0] new_value,
  input  wire logic signed [31:0] nbr_key,
  input  wire logic        [31:0] nbr_value,
  input  wire logic signed [31:0] head_key,
  input  wire logic        [31:0] head_value,
  input  wire logic               seen_in,
  output logic                    seen_out,
  output logic signed [31:0]      key_q,
  output logic        [31:0]      value_q,
  output logic        [31:0]      hit_value
);

  logic match;
  logic first;

  assign match     = ctrl.occ && (key_q == new_key);
  assign first     = match && !seen_in;
  assign seen_out  = seen_in || match;
  assign hit_value = first ? value_q : 32'd0;

  always_ff @(posedge clk) begin
    if (ctrl.add_here) begin
      key_q   <= new_key;
      value_q <= new_value;
    end else if (ctrl.upd && first) begin
      value_q <= new_value;
    end else if (ctrl.del && seen_out) begin
      key_q   <= nbr_key;
      value_q <= nbr_value;
    end else if (ctrl.rotate) begin
      if (ctrl.tail) begin
        key_q   <= head_key;
        value_q <= head_value;
      end else begin
        key_q   <= nbr_key;
        value_q <= nbr_value;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/keyed_record_table_top.sv -----
// ----------------------------------------------------------------------------
// keyed_record_table_top
// Bounded unsorted key/value table held in a row of record cells.
// ----------------------------------------------------------------------------
// Records sit in insertion order in a row of CAPACITY cells; every cell
// compares its key with the request key at once and a first-match signal
// ripples along the row. Add, update and delete are captured in idle and
// acted on in the execute state, which waits while a held response is
// stalled; delete closes the gap by moving every later record one cell down
// in that same cycle. List rotates the row once per record held and the head
// cell feeds the response register. A new request is taken only after the
// previous one has produced its last response; the response register lets
// the next request be captured while that response waits.
`default_nettype none
module keyed_record_table_top
  import krt_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;
  op_t                op_r;
  logic signed [31:0] key_r;
  logic        [31:0] value_r;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] list_cnt, list_cnt_next;
  rsp_t rsp_next;
  logic rsp_load;
  logic can_load;
  logic exec_go;
  logic list_go;
  logic full;
  logic found;
  logic [31:0] removed;

  cell_ctrl_t         ctrl     [CAPACITY];
  logic signed [31:0] cell_key [CAPACITY];
  logic        [31:0] cell_val [CAPACITY];
  logic        [31:0] hit_val  [CAPACITY];
  logic               seen     [CAPACITY+1];

  assign req_stall = (state != ST_IDLE);
  assign can_load  = !rsp_valid || !rsp_stall;
  assign exec_go   = (state == ST_EXEC) && can_load;
  assign list_go   = (state == ST_LIST) && can_load;
  assign full      = (count == CW'(CAPACITY));
  assign seen[0]   = 1'b0;
  assign found     = seen[CAPACITY];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] nk;
      logic        [31:0] nv;
      if (g == CAPACITY - 1) begin : g_end
        assign nk = cell_key[g];
        assign nv = cell_val[g];
      end else begin : g_mid
        assign nk = cell_key[g+1];
        assign nv = cell_val[g+1];
      end

      always_comb begin
        ctrl[g].occ      = (CW'(g) < count);
        ctrl[g].add_here = exec_go && (op_r == OP_ADD) && !full && (CW'(g) == count);
        ctrl[g].upd      = exec_go && (op_r == OP_UPDATE);
        ctrl[g].del      = exec_go && (op_r == OP_DELETE);
        ctrl[g].rotate   = list_go && (CW'(g) < count);
        ctrl[g].tail     = (CW'(g + 1) == count);
      end

      krt_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[g]),
        .new_key    (key_r),
        .new_value  (value_r),
        .nbr_key    (nk),
        .nbr_value  (nv),
        .head_key   (cell_key[0]),
        .head_value (cell_val[0]),
        .seen_in    (seen[g]),
        .seen_out   (seen[g+1]),
        .key_q      (cell_key[g]),
        .value_q    (cell_val[g]),
        .hit_value  (hit_val[g])
      );
    end
  endgenerate

  always_comb begin
    removed = 32'd0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | hit_val[i];
    end
  end

  always_comb begin
    state_next          = state;
    count_next          = count;
    list_cnt_next       = list_cnt;
    rsp_load            = 1'b0;
    rsp_next.status     = STAT_OK;
    rsp_next.rec_key    = key_r;
    rsp_next.rec_value  = 32'd0;
    rsp_next.last       = 1'b1;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (can_load) begin
          case (op_r)
            OP_ADD: begin
              rsp_load = 1'b1;
              state_next = ST_IDLE;
              if (full) begin
                rsp_next.status = STAT_FULL;
              end else begin
                rsp_next.rec_value = value_r;
                count_next = count + CW'(1);
              end
            end
            OP_LIST: begin
              list_cnt_next = '0;
              if (count == '0) begin
                rsp_load = 1'b1;
                rsp_next.status = STAT_EMPTY;
                state_next = ST_IDLE;
              end else begin
                state_next = ST_LIST;
              end
            end
            OP_UPDATE: begin
              rsp_load = 1'b1;
              state_next = ST_IDLE;
              if (found) begin
                rsp_next.rec_value = value_r;
              end else begin
                rsp_next.status = STAT_NOT_FOUND;
              end
            end
            OP_DELETE: begin
              rsp_load = 1'b1;
              state_next = ST_IDLE;
              if (found) begin
                rsp_next.rec_value = removed;
                count_next = count - CW'(1);
              end else begin
                rsp_next.status = STAT_NOT_FOUND;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_LIST: begin
        if (can_load) begin
          rsp_load           = 1'b1;
          rsp_next.rec_key   = cell_key[0];
          rsp_next.rec_value = cell_val[0];
          rsp_next.last      = (list_cnt + CW'(1) == count);
          list_cnt_next      = list_cnt + CW'(1);
          if (list_cnt + CW'(1) == count) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      list_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      list_cnt <= list_cnt_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req_valid) begin
      op_r    <= req.op;
      key_r   <= req.key;
      value_r <= req.value;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("record count above capacity");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LIST) |-> (count != '0) && (list_cnt < count))
    else $error("list walk outside held records");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_EXEC))
    else $error("request accepted without execute cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EXEC) |=> $stable(count))
    else $error("record count changed outside execute");
`endif

endmodule
`default_nettype wire
